### hdl/fisu_pkg.sv
// Package: opcodes, status codes, sequencer states and operand tables for the stack unit.
`default_nettype none
package fisu_pkg;

    localparam int unsigned DEFAULT_MAX_DEPTH = 256;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned LIMIT_W = 9;

    typedef enum logic [4:0] {
        OP_PUSH   = 5'd0,
        OP_POP    = 5'd1,
        OP_TOP    = 5'd2,
        OP_DUP    = 5'd3,
        OP_SWAP   = 5'd4,
        OP_ADD    = 5'd5,
        OP_SUB    = 5'd6,
        OP_MUL    = 5'd7,
        OP_DIV    = 5'd8,
        OP_DIVMOD = 5'd9,
        OP_MOD    = 5'd10,
        OP_OVER   = 5'd11,
        OP_ROT    = 5'd12,
        OP_DROP   = 5'd13,
        OP_2SWAP  = 5'd14,
        OP_2DUP   = 5'd15,
        OP_2OVER  = 5'd16,
        OP_2DROP  = 5'd17
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_DIVZ  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_RD,
        S_RDWAIT,
        S_EXEC,
        S_DIVRUN,
        S_WR,
        S_DONE
    } t_state;

    // Divider control/status between top level and divider.
    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

    // Entries an opcode needs on the stack before it runs.
    function automatic logic [2:0] op_need(input logic [4:0] op);
        logic [2:0] n;
        case (op)
            OP_PUSH:   n = 3'd0;
            OP_POP, OP_TOP, OP_DUP, OP_DROP: n = 3'd1;
            OP_ROT:    n = 3'd3;
            OP_2SWAP, OP_2OVER: n = 3'd4;
            OP_SWAP, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_DIVMOD, OP_MOD,
            OP_OVER, OP_2DUP, OP_2DROP: n = 3'd2;
            default:   n = 3'd0;
        endcase
        return n;
    endfunction

    // Entries an opcode adds to the stack.
    function automatic logic [1:0] op_grow(input logic [4:0] op);
        logic [1:0] g;
        case (op)
            OP_PUSH, OP_DUP, OP_OVER: g = 2'd1;
            OP_2DUP, OP_2OVER:        g = 2'd2;
            default:                  g = 2'd0;
        endcase
        return g;
    endfunction

    // Number of entries read from the top before execution.
    function automatic logic [2:0] op_reads(input logic [4:0] op);
        logic [2:0] r;
        case (op)
            OP_POP, OP_TOP, OP_DUP: r = 3'd1;
            OP_ROT: r = 3'd3;
            OP_2SWAP, OP_2OVER: r = 3'd4;
            OP_SWAP, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_DIVMOD, OP_MOD,
            OP_OVER, OP_2DUP: r = 3'd2;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

### hdl/fisu_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none
module fisu_div
    import fisu_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_div_ctl          i_ctl,
    input  wire logic [DATA_W-1:0] i_dividend,
    input  wire logic [DATA_W-1:0] i_divisor,
    output t_div_sts               o_sts,
    output logic [DATA_W-1:0]      o_quot,
    output logic [DATA_W-1:0]      o_rem
);
    localparam int unsigned CNT_W = $clog2(DATA_W + 1);

    logic [DATA_W-1:0] r_q, n_q;
    logic [DATA_W-1:0] r_r, n_r;
    logic [DATA_W-1:0] r_d, n_d;
    logic              r_qneg, n_qneg;
    logic              r_rneg, n_rneg;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_busy, n_busy;
    logic              r_done, n_done;

    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   shifted;

    // Restoring step on magnitudes
    always_comb begin
        shifted = {r_r, r_q[DATA_W-1]};
        trial   = shifted - {1'b0, r_d};
    end

    always_comb begin
        n_q = r_q; n_r = r_r; n_d = r_d; n_qneg = r_qneg; n_rneg = r_rneg;
        n_cnt = r_cnt; n_busy = r_busy; n_done = 1'b0;
        if (i_ctl.start) begin
            n_q    = i_dividend[DATA_W-1] ? (~i_dividend + 1'b1) : i_dividend;
            n_d    = i_divisor[DATA_W-1] ? (~i_divisor + 1'b1) : i_divisor;
            n_r    = '0;
            n_qneg = i_dividend[DATA_W-1] ^ i_divisor[DATA_W-1];
            n_rneg = i_dividend[DATA_W-1];
            n_cnt  = CNT_W'(DATA_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!trial[DATA_W]) begin
                n_r = trial[DATA_W-1:0];
                n_q = {r_q[DATA_W-2:0], 1'b1};
            end else begin
                n_r = shifted[DATA_W-1:0];
                n_q = {r_q[DATA_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q <= n_q; r_r <= n_r; r_d <= n_d; r_qneg <= n_qneg; r_rneg <= n_rneg;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quot = r_qneg ? (~r_q + 1'b1) : r_q;
    assign o_rem  = r_rneg ? (~r_r + 1'b1) : r_r;
endmodule
`default_nettype wire

### hdl/fisu_stack_ram.sv
// Stack entry memory: one write port and one registered read port.
`default_nettype none
module fisu_stack_ram
    import fisu_pkg::*;
#(
    parameter int unsigned MAX_DEPTH = DEFAULT_MAX_DEPTH,
    parameter int unsigned ADDR_W    = $clog2(MAX_DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0]      o_rdata
);
    logic [DATA_W-1:0] r_mem [MAX_DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### hdl/forth_integer_stack_unit.sv
// Top level: Forth data stack with a small sequencer, one memory read and one write port and a shared divider.
//
// A request is taken when i_start is high and o_busy low; exactly one result
// follows on o_done for one cycle and cannot be held off. A request passes
// through a check state, a read and a read-wait state per entry read (up to
// four), an execute state, a write state per entry written (up to four) and
// a done state; div, divmod and mod with a nonzero divisor add a divider-run
// state that waits for the one-bit-per-cycle divider. o_busy then drops in
// the idle state, where the next request is taken, so requests do not
// overlap. The stack memory needs no clearing: only entries below the depth
// are ever read.
`default_nettype none
module forth_integer_stack_unit
    import fisu_pkg::*;
#(
    parameter int unsigned MAX_DEPTH = DEFAULT_MAX_DEPTH
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    output logic                     o_busy,
    input  wire logic                i_cfg_we,
    input  wire logic [LIMIT_W-1:0]  i_cfg_stack_limit,
    input  wire logic [4:0]          i_req_type,
    input  wire logic signed [DATA_W-1:0] i_push_value,
    output logic                     o_done,
    output logic [1:0]               o_status,
    output logic signed [DATA_W-1:0] o_result_value,
    output logic                     o_value_valid,
    output logic [LIMIT_W-1:0]       o_depth_after
);
    localparam int unsigned ADDR_W  = $clog2(MAX_DEPTH);
    localparam int unsigned DEPTH_W = $clog2(MAX_DEPTH + 1);
    localparam int unsigned CMP_W   = (DEPTH_W > LIMIT_W ? DEPTH_W : LIMIT_W) + 1;

    t_state             r_state, n_state;
    logic [LIMIT_W-1:0] r_limit;
    logic [DEPTH_W-1:0] r_depth, n_depth;
    logic [4:0]         r_op;
    logic [DATA_W-1:0]  r_pv;
    logic [1:0]         r_status, n_status;
    logic [DATA_W-1:0]  r_e [4];        // r_e[k]: entry k below the top
    logic [DATA_W-1:0]  r_w [4];        // values to write, k below new top
    logic [2:0]         r_nrd, r_nwr;
    logic [2:0]         r_idx;
    logic [DATA_W-1:0]  r_rv;
    logic               r_vv;

    logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
    logic [DATA_W-1:0]  ram_rdata, ram_wdata;
    logic               ram_we;
    t_div_ctl           div_ctl;
    t_div_sts           div_sts;
    logic [DATA_W-1:0]  div_q, div_r;
    logic [DATA_W-1:0]  mul_p, alu_y;
    logic [CMP_W-1:0]   lim_now, need_room;

    fisu_stack_ram #(.MAX_DEPTH(MAX_DEPTH), .ADDR_W(ADDR_W)) u_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_waddr), .i_wdata(ram_wdata),
        .i_raddr(ram_raddr), .o_rdata(ram_rdata)
    );

    fisu_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(div_ctl),
        .i_dividend(r_e[1]), .i_divisor(r_e[0]),
        .o_sts(div_sts), .o_quot(div_q), .o_rem(div_r)
    );

    // Limit in force and room check
    assign lim_now   = (CMP_W'(r_limit) < CMP_W'(MAX_DEPTH)) ? CMP_W'(r_limit)
                                                            : CMP_W'(MAX_DEPTH);
    assign need_room = CMP_W'(r_depth) + CMP_W'(op_grow(r_op));
    assign mul_p     = r_e[1] * r_e[0];

    // Shared add/sub unit
    assign alu_y = (r_op == OP_SUB) ? (r_e[1] - r_e[0]) : (r_e[1] + r_e[0]);

    // Memory addresses: entry k below top is depth-1-k
    assign ram_raddr = ADDR_W'(r_depth - DEPTH_W'(1) - DEPTH_W'(r_idx));
    assign ram_waddr = ADDR_W'(n_depth - DEPTH_W'(1) - DEPTH_W'(r_idx));
    assign ram_wdata = r_w[r_idx[1:0]];
    assign ram_we    = (r_state == S_WR);
    // Divider starts only for a nonzero divisor
    assign div_ctl.start = (r_state == S_EXEC) && (r_e[0] != '0) &&
        (r_op == OP_DIV || r_op == OP_DIVMOD || r_op == OP_MOD);

    // Next-state logic
    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        case (r_state)
            S_IDLE: if (i_start) n_state = S_CHECK;
            S_CHECK: begin
                if (r_op > OP_2DROP) begin
                    n_status = ST_OK;
                    n_state  = S_DONE;
                end else if (r_depth < DEPTH_W'(op_need(r_op))) begin
                    n_status = ST_UNDER;
                    n_state  = S_DONE;
                end else if (op_grow(r_op) != 2'd0 && need_room > lim_now) begin
                    n_status = ST_OVER;
                    n_state  = S_DONE;
                end else begin
                    n_status = ST_OK;
                    n_state  = (r_nrd == 3'd0) ? S_EXEC : S_RD;
                end
            end
            S_RD:     n_state = S_RDWAIT;
            S_RDWAIT: n_state = (r_idx + 3'd1 == r_nrd) ? S_EXEC : S_RD;
            S_EXEC: begin
                if ((r_op == OP_DIV || r_op == OP_DIVMOD || r_op == OP_MOD) &&
                    r_e[0] == '0) begin
                    n_status = ST_DIVZ;
                    n_state  = S_DONE;
                end else if (div_ctl.start) begin
                    n_state = S_DIVRUN;
                end else begin
                    // pop, top, drop and 2drop write nothing back
                    n_state = (r_op == OP_POP || r_op == OP_TOP ||
                               r_op == OP_DROP || r_op == OP_2DROP) ? S_DONE : S_WR;
                end
            end
            S_DIVRUN: if (div_sts.done) n_state = S_WR;
            S_WR:     n_state = (r_idx + 3'd1 == r_nwr) ? S_DONE : S_WR;
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Depth after the operation
    always_comb begin
        n_depth = r_depth;
        case (r_op)
            OP_PUSH, OP_DUP, OP_OVER: n_depth = r_depth + DEPTH_W'(1);
            OP_2DUP, OP_2OVER:        n_depth = r_depth + DEPTH_W'(2);
            OP_POP, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_DROP:
                                      n_depth = r_depth - DEPTH_W'(1);
            OP_2DROP:                 n_depth = r_depth - DEPTH_W'(2);
            default:                  n_depth = r_depth;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_limit  <= LIMIT_W'(256);
            r_depth  <= '0;
            r_status <= ST_OK;
            r_idx    <= '0;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
            if (i_cfg_we) r_limit <= i_cfg_stack_limit;
            case (r_state)
                S_CHECK:  r_idx <= '0;
                S_RDWAIT: r_idx <= (n_state == S_EXEC) ? 3'd0 : r_idx + 3'd1;
                S_EXEC, S_DIVRUN: r_idx <= '0;
                S_WR: begin
                    r_idx <= r_idx + 3'd1;
                    if (n_state == S_DONE) r_depth <= n_depth;
                end
                default: r_idx <= r_idx;
            endcase
            // Operations that write nothing back update the depth here
            if (r_state == S_EXEC && n_state == S_DONE && n_status == ST_OK)
                r_depth <= n_depth;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_op  <= i_req_type;
            r_pv  <= i_push_value;
            r_nrd <= op_reads(i_req_type);
            r_rv  <= '0;
            r_vv  <= 1'b0;
        end
        if (r_state == S_RDWAIT) r_e[r_idx[1:0]] <= ram_rdata;
        if (r_state == S_EXEC) begin
            r_nwr <= 3'd0;
            case (r_op)
                OP_PUSH: begin r_w[0] <= r_pv; r_nwr <= 3'd1; end
                OP_POP, OP_TOP: begin r_rv <= r_e[0]; r_vv <= 1'b1; end
                OP_DUP: begin r_w[0] <= r_e[0]; r_nwr <= 3'd1; end
                OP_SWAP: begin r_w[0] <= r_e[1]; r_w[1] <= r_e[0]; r_nwr <= 3'd2; end
                OP_ADD, OP_SUB: begin r_w[0] <= alu_y; r_nwr <= 3'd1; end
                OP_MUL: begin r_w[0] <= mul_p; r_nwr <= 3'd1; end
                OP_DIV, OP_MOD: r_nwr <= 3'd1;
                OP_DIVMOD: r_nwr <= 3'd2;
                OP_OVER: begin r_w[0] <= r_e[1]; r_nwr <= 3'd1; end
                OP_ROT: begin
                    r_w[0] <= r_e[2]; r_w[1] <= r_e[0]; r_w[2] <= r_e[1];
                    r_nwr <= 3'd3;
                end
                OP_2SWAP: begin
                    r_w[0] <= r_e[2]; r_w[1] <= r_e[3];
                    r_w[2] <= r_e[0]; r_w[3] <= r_e[1];
                    r_nwr <= 3'd4;
                end
                OP_2DUP: begin r_w[0] <= r_e[0]; r_w[1] <= r_e[1]; r_nwr <= 3'd2; end
                OP_2OVER: begin r_w[0] <= r_e[2]; r_w[1] <= r_e[3]; r_nwr <= 3'd2; end
                default: r_nwr <= 3'd0;
            endcase
        end
        if (r_state == S_DIVRUN && div_sts.done) begin
            case (r_op)
                OP_DIV:  r_w[0] <= div_q;
                OP_MOD:  r_w[0] <= div_r;
                default: begin r_w[0] <= div_q; r_w[1] <= div_r; end
            endcase
        end
    end

    // Outputs
    always_comb begin
        o_busy         = (r_state != S_IDLE);
        o_done         = (r_state == S_DONE);
        o_status       = r_status;
        o_result_value = (r_status == ST_OK) ? r_rv : '0;
        o_value_valid  = (r_state == S_DONE) && (r_status == ST_OK) && r_vv;
        o_depth_after  = LIMIT_W'(r_depth);
    end

    // Checks
    a_done_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done held two cycles");
    a_valid_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_value_valid |-> (o_done && o_status == ST_OK)) else $error("valid without ok");
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DEPTH_W'(MAX_DEPTH)) else $error("depth beyond storage");
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_sts.busy |-> r_state == S_DIVRUN) else $error("divider busy out of turn");
endmodule
`default_nettype wire

### verif/tb_forth_integer_stack_unit.sv
// Testbench for the Forth stack unit: random and directed requests checked against a predictor.
`default_nettype none
module tb_forth_integer_stack_unit;
    import fisu_pkg::*;

    localparam int unsigned DEPTH_MAX = 256;
    localparam int unsigned IDLE_LIMIT = 2000;
    localparam int unsigned SETTLE_CYCLES = 60;

    typedef struct packed {
        logic [4:0]  op;
        logic [31:0] value;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] value;
        logic        valid;
        logic [8:0]  depth;
    } t_resp;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [8:0]  i_cfg_stack_limit = '0;
    logic [4:0]  i_req_type = '0;
    logic [31:0] i_push_value = '0;
    logic        o_busy;
    logic        o_done;
    logic [1:0]  o_status;
    logic [31:0] o_result_value;
    logic        o_value_valid;
    logic [8:0]  o_depth_after;

    forth_integer_stack_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_cfg_we(i_cfg_we), .i_cfg_stack_limit(i_cfg_stack_limit),
        .i_req_type(i_req_type), .i_push_value(i_push_value),
        .o_done(o_done), .o_status(o_status), .o_result_value(o_result_value),
        .o_value_valid(o_value_valid), .o_depth_after(o_depth_after)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state
    logic [31:0] model_mem [DEPTH_MAX];
    int unsigned model_depth = 0;
    int unsigned model_limit = 256;

    t_req  req_queue[$];
    t_resp expected_q[$];
    int unsigned mismatch_count = 0;
    int unsigned idle_cycles = 0;
    bit          timed_out = 1'b0;

    function automatic logic [31:0] stk(int unsigned k);
        return model_mem[model_depth - 1 - k];
    endfunction

    // Predict the result of one request and update the stack copy
    function automatic t_resp predict_stack_op(t_req r);
        t_resp       res;
        int unsigned need, grow, lim;
        logic [31:0] a, b, c, d;
        logic signed [31:0] n1, n2, q, m;
        res = '0;
        need = 0;
        grow = 0;
        lim = (model_limit < DEPTH_MAX) ? model_limit : DEPTH_MAX;
        if (r.op <= OP_2DROP) begin
            case (t_op'(r.op))
                OP_PUSH: begin need = 0; grow = 1; end
                OP_POP, OP_TOP, OP_DROP: need = 1;
                OP_DUP: begin need = 1; grow = 1; end
                OP_OVER, OP_2DUP: begin need = 2; grow = (r.op == OP_OVER) ? 1 : 2; end
                OP_ROT: need = 3;
                OP_2SWAP: need = 4;
                OP_2OVER: begin need = 4; grow = 2; end
                default: need = 2;
            endcase
            if (model_depth < need) res.status = ST_UNDER;
            else if (grow != 0 && model_depth + grow > lim) res.status = ST_OVER;
            else if ((r.op == OP_DIV || r.op == OP_DIVMOD || r.op == OP_MOD) && stk(0) == 0)
                res.status = ST_DIVZ;
        end
        if (r.op <= OP_2DROP && res.status == ST_OK) begin
            case (t_op'(r.op))
                OP_PUSH: begin model_depth++; model_mem[model_depth-1] = r.value; end
                OP_POP: begin res.value = stk(0); res.valid = 1; model_depth--; end
                OP_TOP: begin res.value = stk(0); res.valid = 1; end
                OP_DUP: begin a = stk(0); model_depth++; model_mem[model_depth-1] = a; end
                OP_SWAP: begin
                    a = stk(0); b = stk(1);
                    model_mem[model_depth-1] = b; model_mem[model_depth-2] = a;
                end
                OP_ADD, OP_SUB, OP_MUL: begin
                    a = (r.op == OP_ADD) ? stk(1) + stk(0) :
                        (r.op == OP_SUB) ? stk(1) - stk(0) : stk(1) * stk(0);
                    model_depth--; model_mem[model_depth-1] = a;
                end
                OP_DIV, OP_DIVMOD, OP_MOD: begin
                    n2 = stk(0); n1 = stk(1);
                    if (n1 == 32'sh8000_0000 && n2 == -32'sd1) begin
                        q = n1; m = 0;
                    end else begin
                        q = n1 / n2; m = n1 % n2;
                    end
                    if (r.op == OP_DIV) begin
                        model_depth--; model_mem[model_depth-1] = q;
                    end else if (r.op == OP_MOD) begin
                        model_depth--; model_mem[model_depth-1] = m;
                    end else begin
                        model_mem[model_depth-2] = m; model_mem[model_depth-1] = q;
                    end
                end
                OP_OVER: begin a = stk(1); model_depth++; model_mem[model_depth-1] = a; end
                OP_ROT: begin
                    c = stk(0); b = stk(1); a = stk(2);
                    model_mem[model_depth-3] = b; model_mem[model_depth-2] = c;
                    model_mem[model_depth-1] = a;
                end
                OP_DROP: model_depth--;
                OP_2SWAP: begin
                    d = stk(0); c = stk(1); b = stk(2); a = stk(3);
                    model_mem[model_depth-4] = c; model_mem[model_depth-3] = d;
                    model_mem[model_depth-2] = a; model_mem[model_depth-1] = b;
                end
                OP_2DUP, OP_2OVER: begin
                    b = (r.op == OP_2DUP) ? stk(0) : stk(2);
                    a = (r.op == OP_2DUP) ? stk(1) : stk(3);
                    model_depth += 2;
                    model_mem[model_depth-2] = a; model_mem[model_depth-1] = b;
                end
                default: model_depth -= 2;
            endcase
        end
        res.depth = model_depth[8:0];
        return res;
    endfunction

    // Driver: bursts of transactions with random gaps
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    always @(posedge i_clk) begin
        t_req nxt;
        if (i_rst_n) begin
            if (i_start && !o_busy) expected_q.push_back(predict_stack_op(req_queue.pop_front()));
            if (i_start && o_busy) begin
                // hold current request
            end else if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                i_start <= 1'b0;
            end else if (req_queue.size() != 0 && !(i_start && req_queue.size() == 0)) begin
                nxt = req_queue[0];
                i_start <= 1'b1;
                i_req_type <= nxt.op;
                i_push_value <= nxt.value;
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // Monitor: compare each result with the oldest expectation
    always @(posedge i_clk) begin
        t_resp got, exp_r;
        if (i_rst_n) begin
            if (o_done || (i_start && !o_busy)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (o_done) begin
                got = '{o_status, o_result_value, o_value_valid, o_depth_after};
                if (expected_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) $display("unexpected result %p", got);
                end else begin
                    exp_r = expected_q.pop_front();
                    if (got !== exp_r) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: expected %p actual %p", exp_r, got);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("tb_forth_integer_stack_unit failed");
            $finish;
        end
    end

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 3);
            3: return 32'h7FFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    task automatic add_req(input t_op op, input logic [31:0] v);
        req_queue.push_back('{op, v});
    endtask

    task automatic wait_drained();
        while (req_queue.size() != 0 || i_start || expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [8:0] lim);
        i_cfg_stack_limit <= lim;
        i_cfg_we <= 1'b1;
        @(posedge i_clk);
        model_limit = lim;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random phase: stack-building ops weighted toward keeping depth moderate
    task automatic random_phase(input int unsigned count, input int unsigned fill_bias);
        int unsigned op;
        repeat (count) begin
            op = $urandom_range(0, 99);
            if (op < fill_bias) add_req(OP_PUSH, rand_value());
            else if (op < 98) add_req(t_op'($urandom_range(1, 17)), rand_value());
            else add_req(t_op'($urandom_range(18, 31)), rand_value());
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: underflow on empty, every opcode, divide corners
        add_req(OP_POP, 0);
        add_req(OP_2DROP, 0);
        add_req(OP_PUSH, 32'h8000_0000);
        add_req(OP_PUSH, 32'hFFFF_FFFF);
        add_req(OP_DIV, 0);
        add_req(OP_PUSH, 0);
        add_req(OP_MOD, 0);
        add_req(OP_DROP, 0);
        add_req(OP_PUSH, 32'h7FFF_FFFF);
        add_req(OP_PUSH, -7);
        add_req(OP_DIVMOD, 0);
        add_req(OP_ROT, 0);
        add_req(OP_2SWAP, 0);
        add_req(OP_2OVER, 0);
        add_req(OP_2DUP, 0);
        add_req(OP_OVER, 0);
        add_req(OP_SWAP, 0);
        add_req(OP_ADD, 0);
        add_req(OP_SUB, 0);
        add_req(OP_MUL, 0);
        add_req(OP_DUP, 0);
        add_req(OP_TOP, 0);
        add_req(t_op'(5'd31), 32'h5A5A_5A5A);
        add_req(OP_2DROP, 0);
        wait_drained();

        // Limit settings including the extremes; lowering below depth too
        write_limit(9'd0);
        random_phase(60, 40);
        wait_drained();
        write_limit(9'd4);
        random_phase(300, 45);
        wait_drained();
        write_limit(9'd2);
        random_phase(200, 40);
        wait_drained();
        write_limit(9'd511);
        random_phase(700, 70);
        wait_drained();
        write_limit(9'd256);
        random_phase(300, 60);
        wait_drained();
        write_limit(9'd7);
        random_phase(300, 45);
        wait_drained();

        if (mismatch_count == 0 && expected_q.size() == 0)
            $display("tb_forth_integer_stack_unit passed");
        else
            $display("tb_forth_integer_stack_unit failed");
        $finish;
    end
endmodule
`default_nettype wire
